/* hdl/tw_odo_pkg.sv */
package tw_odo_pkg;

	localparam int CORDIC_STEPS_DEF = 24;

	// CORDIC datapath widths and angle table index width
	localparam int CW  = 34;
	localparam int ZW  = 33;
	localparam int AIW = 5;

	localparam logic [29:0] PI_Q28   = 30'd843314857;
	localparam logic [29:0] RAD2BA   = 30'd683565276;
	localparam logic [29:0] GAIN_Q30 = 30'd652032875;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SET    = 2'd1,
		CMD_ZERO   = 2'd2
	} cmd_t;

	function automatic logic [31:0] atan_ba(input logic [AIW-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			5'd30: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

/* hdl/tw_odo_div.sv */
module tw_odo_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [31:0] rem
);

	logic [63:0] qd_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [32:0] rem_sh;
	logic [32:0] diff;
	logic        fit;

	// one quotient bit per cycle, restoring
	assign rem_sh = {rem_q[31:0], qd_q[63]};
	assign diff   = rem_sh - {1'b0, dvs_q};
	assign fit    = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			qd_q   <= '0;
			rem_q  <= '0;
			dvs_q  <= '0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				qd_q   <= dividend;
				rem_q  <= '0;
				dvs_q  <= divisor;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= fit ? diff : rem_sh;
				qd_q  <= {qd_q[62:0], fit};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quot = qd_q;
	assign rem  = rem_q[31:0];

endmodule

/* hdl/tw_odo_cordic.sv */
module tw_odo_cordic #(
	parameter int STEPS = tw_odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [31:0]                        angle,
	output logic                               done,
	output logic signed [tw_odo_pkg::CW-1:0]   sin_val,
	output logic signed [tw_odo_pkg::CW-1:0]   cos_val
);
	import tw_odo_pkg::*;

	localparam logic signed [ZW-1:0] QTR  = 33'sd1073741824;
	localparam logic signed [ZW-1:0] HLF  = 33'sd2147483648;
	localparam logic [AIW-1:0]       LAST = AIW'(STEPS - 1);

	logic signed [CW-1:0] x_q, y_q, xs, ys;
	logic signed [ZW-1:0] z_q, z0, zf, at;
	logic                 neg_q, fold;
	logic [AIW-1:0]       i_q;
	logic                 busy_q, done_q;

	always_comb begin
		z0   = ZW'(signed'(angle));
		fold = (z0 > QTR) || (z0 < -QTR);
		if (z0 > QTR)
			zf = z0 - HLF;
		else if (z0 < -QTR)
			zf = z0 + HLF;
		else
			zf = z0;
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		at = signed'({1'b0, atan_ba(i_q)});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			x_q    <= '0;
			y_q    <= '0;
			z_q    <= '0;
			neg_q  <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q    <= CW'(GAIN_Q30);
				y_q    <= '0;
				z_q    <= zf;
				neg_q  <= fold;
				i_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (!z_q[ZW-1]) begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + at;
				end
				i_q <= i_q + 1'b1;
				if (i_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done    = done_q;
	assign sin_val = neg_q ? -y_q : y_q;
	assign cos_val = neg_q ? -x_q : x_q;

endmodule

/* hdl/three_wheel_odometry_unit.sv */
// Channel   Direction  Handshake               Payload
// request   in         req_valid / req_stall   cmd, enc_left/mid/right, set_x/y/heading
// result    out        res_valid / res_stall   pos_x, pos_y, heading
// config    in         APB psel/penable/pwrite paddr[4:2] register, pwdata / prdata
//
// Set pose, zero and unused commands go from idle straight to the done state, which loads the result.
// A sample takes at most nine passes through the radix-2 divider,
// two CORDIC runs and the shared multiplier.
// req_stall is high from acceptance until the result is loaded into the output
// register; a stalled result holds there while the next request is accepted.
// Reset loads the register defaults and zeroes pose and encoder baselines.
module three_wheel_odometry_unit #(
	parameter int CORDIC_STEPS = tw_odo_pkg::CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic signed [31:0] enc_left,
	input  logic signed [31:0] enc_mid,
	input  logic signed [31:0] enc_right,
	input  logic signed [31:0] set_x,
	input  logic signed [31:0] set_y,
	input  logic signed [31:0] set_heading,
	output logic        res_valid,
	input  logic        res_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] heading
);
	import tw_odo_pkg::*;

	typedef enum logic [2:0] {
		REG_DIAM = 3'd0,
		REG_LOFF = 3'd1,
		REG_MOFF = 3'd2,
		REG_ROFF = 3'd3,
		REG_TPR  = 3'd4
	} reg_idx_t;

	typedef enum logic [5:0] {
		S_IDLE, S_ARC_MUL, S_ARC_D1, S_ARC_D1W, S_ARC_RMUL, S_ARC_D2, S_ARC_D2W,
		S_ARC_QMUL, S_ARC_FIN, S_TRN_D1, S_TRN_D1W, S_TRN_RMUL, S_TRN_D2, S_TRN_D2W,
		S_TRN_QMUL, S_TRN_FIN, S_SIN, S_SIN_W, S_F_MUL, S_F_DIV, S_F_DIVW,
		S_H_P1, S_H_P2, S_H_P3, S_H_RND, S_E, S_E_W, S_X_P1, S_X_P2, S_X_P3,
		S_X_RND, S_X_UPD, S_DONE
	} state_t;

	state_t state_q;

	logic [19:0]        diam_q, loff_q, roff_q;
	logic signed [20:0] moff_q;
	logic [15:0]        tpr_q;

	logic [31:0]        prev_l_q, prev_m_q, prev_r_q;
	logic signed [31:0] pose_x_q, pose_y_q;
	logic [31:0]        head_q;
	logic [31:0]        dl_q, dm_q, dr_q;
	logic signed [31:0] arc_l_q, arc_m_q, arc_r_q;
	logic [1:0]         w_q;
	logic [31:0]        qsav_q, rsav_q, q2_q;
	logic               neg_q, sat_q, sec_q;
	logic signed [31:0] t_q;
	logic signed [CW-1:0] s_q, se_q, ce_q;
	logic [31:0]        fmag_q;
	logic               fneg_q;
	logic signed [65:0] acc_q;
	logic signed [32:0] h_q, h2_q;
	logic signed [35:0] rnd_q;
	logic               res_valid_q;
	logic signed [31:0] out_x_q, out_y_q, out_h_q;
	logic [63:0]        mul_q;

	logic               cfg_wr, accept;
	logic [31:0]        d_sel, d_mag;
	logic [15:0]        tpr_eff;
	logic signed [32:0] num;
	logic [32:0]        num_mag;
	logic [20:0]        den;
	logic [31:0]        t_mag;
	logic signed [31:0] half_c;
	logic [CW-1:0]      s_abs, se_abs, ce_abs;
	logic [31:0]        arc_r_mag, arc_m_mag, mo_mag, h_mag, h2_mag;
	logic [31:0]        mul_a, mul_b;
	logic               psg;
	logic signed [65:0] pterm, acc_base, acc_sum, rnd_pre, rnd_full;
	logic signed [32:0] h_clamp;
	logic [63:0]        arc_f, arc_rnd;
	logic [35:0]        arc_res;
	logic [31:0]        arc_mag;
	logic signed [31:0] arc_val;
	logic [33:0]        trn_sum;
	logic [31:0]        trn_mag;
	logic signed [31:0] trn_val;
	logic signed [31:0] pose_sel, pose_sat;
	logic signed [36:0] pose_sum;

	logic               div_start, div_done;
	logic [63:0]        div_dvd, div_quot;
	logic [31:0]        div_dvs, div_rem;
	logic               cor_start, cor_done;
	logic [31:0]        cor_ang;
	logic signed [CW-1:0] cor_sin, cor_cos;

	tw_odo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	tw_odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start),
		.angle   (cor_ang),
		.done    (cor_done),
		.sin_val (cor_sin),
		.cos_val (cor_cos)
	);

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	always_comb begin
		case (paddr[4:2])
			REG_DIAM: prdata = {12'b0, diam_q};
			REG_LOFF: prdata = {12'b0, loff_q};
			REG_MOFF: prdata = 32'(moff_q);
			REG_ROFF: prdata = {12'b0, roff_q};
			REG_TPR:  prdata = {16'b0, tpr_q};
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		case (w_q)
			2'd0:    d_sel = dl_q;
			2'd1:    d_sel = dm_q;
			default: d_sel = dr_q;
		endcase
		d_mag     = d_sel[31] ? -d_sel : d_sel;
		tpr_eff   = (tpr_q == '0) ? 16'd1 : tpr_q;
		num       = 33'(arc_l_q) - 33'(arc_r_q);
		num_mag   = num[32] ? 33'(-num) : 33'(num);
		den       = {1'b0, loff_q} + {1'b0, roff_q};
		t_mag     = t_q[31] ? 32'(-t_q) : 32'(t_q);
		// halve toward zero
		half_c    = signed'(t_q + 32'(t_q[31])) >>> 1;
		s_abs     = s_q[CW-1] ? CW'(-s_q) : CW'(s_q);
		se_abs    = se_q[CW-1] ? CW'(-se_q) : CW'(se_q);
		ce_abs    = ce_q[CW-1] ? CW'(-ce_q) : CW'(ce_q);
		arc_r_mag = arc_r_q[31] ? 32'(-arc_r_q) : 32'(arc_r_q);
		arc_m_mag = arc_m_q[31] ? 32'(-arc_m_q) : 32'(arc_m_q);
		mo_mag    = moff_q[20] ? 32'(-moff_q) : 32'(moff_q);
		h_mag     = h_q[32] ? 32'(-h_q) : h_q[31:0];
		h2_mag    = h2_q[32] ? 32'(-h2_q) : h2_q[31:0];
	end

	// shared multiplier operands
	always_comb begin
		case (state_q)
			S_ARC_MUL:  begin mul_a = d_mag;  mul_b = {12'b0, diam_q}; end
			S_ARC_RMUL: begin mul_a = rsav_q; mul_b = {2'b0, PI_Q28};  end
			S_ARC_QMUL: begin mul_a = qsav_q; mul_b = {2'b0, PI_Q28};  end
			S_TRN_RMUL: begin mul_a = rsav_q; mul_b = {2'b0, RAD2BA};  end
			S_TRN_QMUL: begin mul_a = qsav_q; mul_b = {2'b0, RAD2BA};  end
			S_F_MUL:    begin mul_a = s_abs[31:0]; mul_b = {2'b0, RAD2BA}; end
			S_H_P1: begin
				mul_a = sec_q ? arc_m_mag : arc_r_mag;
				mul_b = fmag_q;
			end
			S_H_P2: begin
				mul_a = sec_q ? mo_mag : {12'b0, roff_q};
				mul_b = {s_abs[30:0], 1'b0};
			end
			S_X_P1: begin
				mul_a = h_mag;
				mul_b = sec_q ? ce_abs[31:0] : se_abs[31:0];
			end
			S_X_P2: begin
				mul_a = h2_mag;
				mul_b = sec_q ? se_abs[31:0] : ce_abs[31:0];
			end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// signed accumulate of the last product
	always_comb begin
		case (state_q)
			S_H_P2:  psg = (sec_q ? arc_m_q[31] : arc_r_q[31]) ^ fneg_q;
			S_H_P3:  psg = s_q[CW-1] ^ (sec_q & moff_q[20]);
			S_X_P2:  psg = h_q[32] ^ (sec_q ? ce_q[CW-1] : se_q[CW-1]);
			S_X_P3:  psg = h2_q[32] ^ (sec_q ? se_q[CW-1] : ce_q[CW-1]) ^ sec_q;
			default: psg = 1'b0;
		endcase
		pterm    = signed'({2'b00, mul_q});
		acc_base = (state_q == S_H_P3 || state_q == S_X_P3) ? acc_q : 66'sd0;
		acc_sum  = acc_base + (psg ? -pterm : pterm);
		// round half away from zero, then shift by 30
		rnd_pre  = acc_q + (acc_q[65] ? 66'sd536870911 : 66'sd536870912);
		rnd_full = rnd_pre >>> 30;
		if (rnd_full > 66'sd2147483648)
			h_clamp = 33'sd2147483648;
		else if (rnd_full < -66'sd2147483648)
			h_clamp = -33'sd2147483648;
		else
			h_clamp = rnd_full[32:0];
		pose_sel = sec_q ? pose_y_q : pose_x_q;
		pose_sum = 37'(pose_sel) + 37'(rnd_q);
		if (pose_sum > 37'sd2147483647)
			pose_sat = 32'sh7FFFFFFF;
		else if (pose_sum < -37'sd2147483648)
			pose_sat = 32'sh80000000;
		else
			pose_sat = pose_sum[31:0];
	end

	always_comb begin
		arc_f   = mul_q + {32'b0, q2_q};
		arc_rnd = arc_f + 64'd134217728;
		arc_res = arc_rnd[63:28];
		if (sat_q || arc_res > 36'd2147483647)
			arc_mag = 32'h7FFFFFFF;
		else
			arc_mag = arc_res[31:0];
		arc_val = neg_q ? -signed'(arc_mag) : signed'(arc_mag);
		trn_sum = mul_q[33:0] + {2'b0, q2_q};
		if (sat_q || trn_sum > 34'd2147483647)
			trn_mag = 32'h7FFFFFFF;
		else
			trn_mag = trn_sum[31:0];
		trn_val = neg_q ? -signed'(trn_mag) : signed'(trn_mag);
	end

	always_comb begin
		div_start = 1'b0;
		div_dvd   = mul_q;
		div_dvs   = {16'b0, tpr_eff};
		case (state_q)
			S_ARC_D1, S_ARC_D2: div_start = 1'b1;
			S_TRN_D1: begin
				div_start = (den != '0);
				div_dvd   = {31'b0, num_mag};
				div_dvs   = {11'b0, den};
			end
			S_TRN_D2: begin
				div_start = 1'b1;
				div_dvs   = {11'b0, den};
			end
			S_F_DIV: begin
				div_start = 1'b1;
				div_dvd   = {mul_q[62:0], 1'b0};
				div_dvs   = t_mag;
			end
			default: div_start = 1'b0;
		endcase
		cor_start = (state_q == S_SIN) || (state_q == S_E);
		cor_ang   = (state_q == S_E) ? head_q + 32'(half_c) : 32'(half_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			diam_q      <= 20'd69850;
			loff_q      <= 20'd100000;
			moff_q      <= 21'sd100000;
			roff_q      <= 20'd100000;
			tpr_q       <= 16'd360;
			prev_l_q    <= '0;
			prev_m_q    <= '0;
			prev_r_q    <= '0;
			pose_x_q    <= '0;
			pose_y_q    <= '0;
			head_q      <= '0;
			dl_q        <= '0;
			dm_q        <= '0;
			dr_q        <= '0;
			arc_l_q     <= '0;
			arc_m_q     <= '0;
			arc_r_q     <= '0;
			w_q         <= '0;
			qsav_q      <= '0;
			rsav_q      <= '0;
			q2_q        <= '0;
			neg_q       <= 1'b0;
			sat_q       <= 1'b0;
			sec_q       <= 1'b0;
			t_q         <= '0;
			s_q         <= '0;
			se_q        <= '0;
			ce_q        <= '0;
			fmag_q      <= '0;
			fneg_q      <= 1'b0;
			acc_q       <= '0;
			h_q         <= '0;
			h2_q        <= '0;
			rnd_q       <= '0;
			res_valid_q <= 1'b0;
			out_x_q     <= '0;
			out_y_q     <= '0;
			out_h_q     <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[4:2])
					REG_DIAM: diam_q <= pwdata[19:0];
					REG_LOFF: loff_q <= pwdata[19:0];
					REG_MOFF: moff_q <= signed'(pwdata[20:0]);
					REG_ROFF: roff_q <= pwdata[19:0];
					REG_TPR:  tpr_q  <= pwdata[15:0];
					default:  ;
				endcase
			end

			// drop the taken result unless a new one is loaded this cycle
			if (res_valid_q && !res_stall && state_q != S_DONE)
				res_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DONE;
						case (cmd)
							CMD_SAMPLE: begin
								dl_q     <= enc_left - prev_l_q;
								dm_q     <= enc_mid - prev_m_q;
								dr_q     <= enc_right - prev_r_q;
								prev_l_q <= enc_left;
								prev_m_q <= enc_mid;
								prev_r_q <= enc_right;
								w_q      <= 2'd0;
								state_q  <= S_ARC_MUL;
							end
							CMD_SET: begin
								pose_x_q <= set_x;
								pose_y_q <= set_y;
								head_q   <= set_heading;
							end
							CMD_ZERO: begin
								pose_x_q <= '0;
								pose_y_q <= '0;
								head_q   <= '0;
								prev_l_q <= '0;
								prev_m_q <= '0;
								prev_r_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_ARC_MUL: begin
					neg_q   <= d_sel[31];
					state_q <= S_ARC_D1;
				end
				S_ARC_D1: state_q <= S_ARC_D1W;
				S_ARC_D1W: begin
					if (div_done) begin
						if (div_quot[63:32] != '0) begin
							sat_q   <= 1'b1;
							state_q <= S_ARC_FIN;
						end else begin
							sat_q   <= 1'b0;
							qsav_q  <= div_quot[31:0];
							rsav_q  <= div_rem;
							state_q <= S_ARC_RMUL;
						end
					end
				end
				S_ARC_RMUL: state_q <= S_ARC_D2;
				S_ARC_D2:   state_q <= S_ARC_D2W;
				S_ARC_D2W: begin
					if (div_done) begin
						q2_q    <= div_quot[31:0];
						state_q <= S_ARC_QMUL;
					end
				end
				S_ARC_QMUL: state_q <= S_ARC_FIN;
				S_ARC_FIN: begin
					case (w_q)
						2'd0:    arc_l_q <= arc_val;
						2'd1:    arc_m_q <= arc_val;
						default: arc_r_q <= arc_val;
					endcase
					if (w_q == 2'd2) begin
						state_q <= S_TRN_D1;
					end else begin
						w_q     <= w_q + 2'd1;
						state_q <= S_ARC_MUL;
					end
				end
				S_TRN_D1: begin
					neg_q <= num[32];
					if (den == '0) begin
						// no track width: straight-line move
						t_q     <= '0;
						h_q     <= 33'(arc_r_q);
						h2_q    <= 33'(arc_m_q);
						state_q <= S_E;
					end else begin
						state_q <= S_TRN_D1W;
					end
				end
				S_TRN_D1W: begin
					if (div_done) begin
						if (div_quot[63:2] != '0) begin
							sat_q   <= 1'b1;
							state_q <= S_TRN_FIN;
						end else begin
							sat_q   <= 1'b0;
							qsav_q  <= div_quot[31:0];
							rsav_q  <= div_rem;
							state_q <= S_TRN_RMUL;
						end
					end
				end
				S_TRN_RMUL: state_q <= S_TRN_D2;
				S_TRN_D2:   state_q <= S_TRN_D2W;
				S_TRN_D2W: begin
					if (div_done) begin
						q2_q    <= div_quot[31:0];
						state_q <= S_TRN_QMUL;
					end
				end
				S_TRN_QMUL: state_q <= S_TRN_FIN;
				S_TRN_FIN: begin
					t_q <= trn_val;
					if (trn_mag == '0) begin
						h_q     <= 33'(arc_r_q);
						h2_q    <= 33'(arc_m_q);
						state_q <= S_E;
					end else begin
						state_q <= S_SIN;
					end
				end
				S_SIN: state_q <= S_SIN_W;
				S_SIN_W: begin
					if (cor_done) begin
						s_q     <= cor_sin;
						state_q <= S_F_MUL;
					end
				end
				S_F_MUL: state_q <= S_F_DIV;
				S_F_DIV: state_q <= S_F_DIVW;
				S_F_DIVW: begin
					if (div_done) begin
						fmag_q  <= div_quot[31:0];
						fneg_q  <= s_q[CW-1] ^ t_q[31];
						sec_q   <= 1'b0;
						state_q <= S_H_P1;
					end
				end
				S_H_P1: state_q <= S_H_P2;
				S_H_P2: begin
					acc_q   <= acc_sum;
					state_q <= S_H_P3;
				end
				S_H_P3: begin
					acc_q   <= acc_sum;
					state_q <= S_H_RND;
				end
				S_H_RND: begin
					if (!sec_q) begin
						h_q     <= h_clamp;
						sec_q   <= 1'b1;
						state_q <= S_H_P1;
					end else begin
						h2_q    <= h_clamp;
						state_q <= S_E;
					end
				end
				S_E: state_q <= S_E_W;
				S_E_W: begin
					if (cor_done) begin
						se_q    <= cor_sin;
						ce_q    <= cor_cos;
						sec_q   <= 1'b0;
						state_q <= S_X_P1;
					end
				end
				S_X_P1: state_q <= S_X_P2;
				S_X_P2: begin
					acc_q   <= acc_sum;
					state_q <= S_X_P3;
				end
				S_X_P3: begin
					acc_q   <= acc_sum;
					state_q <= S_X_RND;
				end
				S_X_RND: begin
					rnd_q   <= signed'(rnd_full[35:0]);
					state_q <= S_X_UPD;
				end
				S_X_UPD: begin
					if (!sec_q) begin
						pose_x_q <= pose_sat;
						sec_q    <= 1'b1;
						state_q  <= S_X_P1;
					end else begin
						pose_y_q <= pose_sat;
						head_q   <= head_q + 32'(t_q);
						state_q  <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!res_valid_q || !res_stall) begin
						out_x_q     <= pose_x_q;
						out_y_q     <= pose_y_q;
						out_h_q     <= signed'(head_q);
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign pos_x     = out_x_q;
	assign pos_y     = out_y_q;
	assign heading   = out_h_q;

endmodule
